// File: hdl/cri_pkg.sv
// Shared widths, register codes, knot colour ROM and types of the colour ramp block.
package cri_pkg;

  localparam int MAX_COLORS = 4096;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 13;
  localparam int MAP_W      = 3;
  localparam int KNOT_W     = 3;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int RGB_W      = NUM_CH * CH_W;
  localparam int REM_W      = IDX_W;
  localparam int WORD_W     = CH_W;
  localparam int POS_W      = IDX_W + KNOT_W;
  localparam int ACC_W      = CH_W + IDX_W;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;

  // Stage 0 front, three knot-position cells, blend, eight colour cells.
  localparam int KPOS_CELLS = KNOT_W;
  localparam int CHAN_CELLS = WORD_W;
  localparam int BLEND_STG  = KPOS_CELLS + 1;
  localparam int PIPE_DEPTH = KPOS_CELLS + CHAN_CELLS + 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAP_SELECT  = 8'd0,
    REG_COLOR_COUNT = 8'd1
  } reg_idx_e;

  typedef struct packed {
    logic [MAP_W-1:0] map_select;
    logic [IDX_W-1:0] last_entry;
  } cfg_t;

  typedef struct packed {
    logic                  in_ready;
    logic                  out_valid;
    logic                  last;
    logic [PIPE_DEPTH-1:0] load;
  } flow_t;

  // Knot colours as {red, green, blue}, addressed by {map, knot}.
  localparam logic [RGB_W-1:0] KNOT_ROM [64] = '{
    24'h281414, 24'h7f0000, 24'he67f00, 24'hffb44d,
    24'hffffff, 24'h000000, 24'h000000, 24'h000000,
    24'h1e1e1e, 24'hffffff, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'hffffff, 24'h1e1e1e, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h285000, 24'hffff00, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h00004d, 24'h0000cc, 24'h00ffff, 24'h99ff4d,
    24'hffff00, 24'hff9900, 24'hff0000, 24'h000000,
    24'h1e1e1e, 24'hc81e1e, 24'he6e61e, 24'h1e1eff,
    24'hffffff, 24'h000000, 24'h000000, 24'h000000,
    24'h1e1e1e, 24'h1e1ec8, 24'h1ec81e, 24'he61e1e,
    24'hf5f51e, 24'hffffff, 24'h000000, 24'h000000,
    24'h640000, 24'hebff00, 24'h00ebff, 24'h820082,
    24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

  // Index of the final knot of each map.
  localparam logic [KNOT_W-1:0] KNOT_LAST [8] = '{
    3'd4, 3'd1, 3'd1, 3'd1, 3'd6, 3'd4, 3'd5, 3'd3
  };

  function automatic logic [RGB_W-1:0] knot_rgb(input logic [MAP_W-1:0]  map,
                                                input logic [KNOT_W-1:0] k);
    return KNOT_ROM[{map, k}];
  endfunction

  function automatic logic [KNOT_W-1:0] knot_last(input logic [MAP_W-1:0] map);
    return KNOT_LAST[map];
  endfunction

endpackage

// File: hdl/cri_stream_if.sv
// Handshake interfaces for the index, colour and configuration channels.
interface cri_in_if import cri_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

interface cri_out_if import cri_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface cri_cfg_if import cri_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/colormap_ramp_interpolator.sv
// Top level of the piecewise-linear colour ramp lookup.
//
//   channel   direction  payload                       role
//   cfg_if    sink       index[7:0], data[15:0]        register write, always taken
//   in_if     sink       index[11:0]                   palette entry wanted
//   out_if    source     red[7:0], green[7:0], blue[7:0]  interpolated colour
//
// One word per clock in and out while the output is not stalled. Stages: entry
// stage, three knot-position division cells, blend stage, eight colour division cells.
// The row of restoring-division cells (one quotient bit each) sets the depth.
// Reset clears the stage valid flags and loads map 0 with a 256-entry ramp.
// A stalled output holds its word; empty stages upstream keep taking words
// until the row is full, then in_if.ready drops.
module colormap_ramp_interpolator import cri_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cri_cfg_if.sink    cfg_if,
  cri_in_if.sink     in_if,
  cri_out_if.source  out_if
);

  logic [MAP_W-1:0] map_select_d, map_select_q;
  logic [IDX_W-1:0] last_entry_d, last_entry_q;
  logic [CNT_W-1:0] count_wr;
  cfg_t             cfg;
  flow_t            flow;
  logic             front_last;

  // Knot-position divider chain: index 0 is the entry stage output.
  logic [REM_W-1:0]  kp_rem  [KPOS_CELLS+1];
  logic [WORD_W-1:0] kp_word [KPOS_CELLS+1];

  logic [ACC_W-1:0]  acc [NUM_CH];

  // Colour divider chains, one per channel.
  logic [REM_W-1:0]  ch_rem  [NUM_CH][CHAN_CELLS+1];
  logic [WORD_W-1:0] ch_word [NUM_CH][CHAN_CELLS+1];

  logic [RGB_W-1:0]  end_rgb;

  // Configuration: always ready; fold the count into the index of the final entry.
  assign cfg_if.ready = 1'b1;
  assign count_wr     = cfg_if.data[CNT_W-1:0];

  always_comb begin
    map_select_d = map_select_q;
    last_entry_d = last_entry_q;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_MAP_SELECT: begin
          map_select_d = cfg_if.data[MAP_W-1:0];
        end
        REG_COLOR_COUNT: begin
          if (count_wr == '0) begin
            last_entry_d = '0;
          end else if (count_wr > CNT_W'(MAX_COLORS)) begin
            last_entry_d = IDX_W'(MAX_COLORS - 1);
          end else begin
            last_entry_d = IDX_W'(count_wr - CNT_W'(1));
          end
        end
        default: begin
          // drop writes beyond the register list
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_select_q <= '0;
      last_entry_q <= IDX_W'(255);
    end else begin
      map_select_q <= map_select_d;
      last_entry_q <= last_entry_d;
    end
  end

  assign cfg.map_select = map_select_q;
  assign cfg.last_entry = last_entry_q;

  // Stage valid flags and advance enables.
  cri_flow u_flow (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .out_ready_i(out_if.ready),
    .last_i     (front_last),
    .flow_o     (flow)
  );

  assign in_if.ready = flow.in_ready;

  cri_front u_front (
    .clk_i  (clk_i),
    .en_i   (flow.load[0]),
    .cfg_i  (cfg),
    .index_i(in_if.index),
    .last_o (front_last),
    .rem_o  (kp_rem[0]),
    .word_o (kp_word[0])
  );

  // Knot index k and remainder r of the position over the final entry.
  for (genvar s = 0; s < KPOS_CELLS; s++) begin : g_kpos
    cri_div_cell u_cell (
      .clk_i    (clk_i),
      .en_i     (flow.load[1+s]),
      .divisor_i(last_entry_q),
      .rem_i    (kp_rem[s]),
      .word_i   (kp_word[s]),
      .rem_o    (kp_rem[s+1]),
      .word_o   (kp_word[s+1])
    );
  end

  cri_blend u_blend (
    .clk_i (clk_i),
    .en_i  (flow.load[BLEND_STG]),
    .cfg_i (cfg),
    .rem_i (kp_rem[KPOS_CELLS]),
    .word_i(kp_word[KPOS_CELLS]),
    .acc_o (acc)
  );

  // Truncating divide of each weighted sum; the quotient is below 256 so the
  // upper bits of the sum already sit below the divisor.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    assign ch_rem[c][0]  = acc[c][ACC_W-1:WORD_W];
    assign ch_word[c][0] = acc[c][WORD_W-1:0];
    for (genvar s = 0; s < CHAN_CELLS; s++) begin : g_cell
      cri_div_cell u_cell (
        .clk_i    (clk_i),
        .en_i     (flow.load[BLEND_STG+1+s]),
        .divisor_i(last_entry_q),
        .rem_i    (ch_rem[c][s]),
        .word_i   (ch_word[c][s]),
        .rem_o    (ch_rem[c][s+1]),
        .word_o   (ch_word[c][s+1])
      );
    end
  end

  // The final entry, including a one-entry ramp, shows the final knot as is.
  assign end_rgb = knot_rgb(map_select_q, knot_last(map_select_q));

  assign out_if.valid = flow.out_valid;
  assign out_if.red   = flow.last ? end_rgb[2*CH_W +: CH_W] : ch_word[0][CHAN_CELLS];
  assign out_if.green = flow.last ? end_rgb[CH_W +: CH_W]   : ch_word[1][CHAN_CELLS];
  assign out_if.blue  = flow.last ? end_rgb[0 +: CH_W]      : ch_word[2][CHAN_CELLS];

endmodule

// File: hdl/cri_div_cell.sv
// One restoring-division cell: brings in a dividend bit, yields one quotient bit.
module cri_div_cell import cri_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [REM_W-1:0]  divisor_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [WORD_W-1:0] word_i,
  output logic [REM_W-1:0]  rem_o,
  output logic [WORD_W-1:0] word_o
);

  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              qbit;
  logic [REM_W-1:0]  rem_d, rem_q;
  logic [WORD_W-1:0] word_d, word_q;

  always_comb begin
    trial  = {rem_i, word_i[WORD_W-1]};
    diff   = trial - {1'b0, divisor_i};
    qbit   = (trial >= {1'b0, divisor_i});
    rem_d  = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    word_d = {word_i[WORD_W-2:0], qbit};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      word_q <= word_d;
    end
  end

  assign rem_o  = rem_q;
  assign word_o = word_q;

endmodule

// File: hdl/cri_front.sv
// Entry stage: clamp the index, flag the final entry, form the scaled knot position.
module cri_front import cri_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic [IDX_W-1:0]  index_i,
  output logic              last_o,
  output logic [REM_W-1:0]  rem_o,
  output logic [WORD_W-1:0] word_o
);

  logic [IDX_W-1:0]  idx_c;
  logic [KNOT_W-1:0] kl;
  logic [POS_W-1:0]  pos_d, pos_q;

  always_comb begin
    idx_c  = (index_i > cfg_i.last_entry) ? cfg_i.last_entry : index_i;
    last_o = (idx_c == cfg_i.last_entry);
    kl     = knot_last(cfg_i.map_select);
    pos_d  = POS_W'(idx_c) * POS_W'(kl);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= pos_d;
    end
  end

  // Quotient fits in KNOT_W bits, so the upper bits already sit below the divisor.
  assign rem_o  = pos_q[POS_W-1:KNOT_W];
  assign word_o = {pos_q[KNOT_W-1:0], (WORD_W-KNOT_W)'(0)};

endmodule

// File: hdl/cri_blend.sv
// Blend stage: weight the two neighbouring knots of each channel by the remainder.
module cri_blend import cri_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  cfg_t              cfg_i,
  input  logic [REM_W-1:0]  rem_i,
  input  logic [WORD_W-1:0] word_i,
  output logic [ACC_W-1:0]  acc_o [NUM_CH]
);

  logic [KNOT_W-1:0] k;
  logic [KNOT_W-1:0] k_nx;
  logic [RGB_W-1:0]  a_rgb;
  logic [RGB_W-1:0]  b_rgb;
  logic [IDX_W-1:0]  w_lo;
  logic [ACC_W-1:0]  acc_d [NUM_CH];
  logic [ACC_W-1:0]  acc_q [NUM_CH];

  always_comb begin
    k     = word_i[KNOT_W-1:0];
    k_nx  = k + KNOT_W'(1);
    a_rgb = knot_rgb(cfg_i.map_select, k);
    b_rgb = knot_rgb(cfg_i.map_select, k_nx);
    w_lo  = cfg_i.last_entry - rem_i;
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    localparam int SH = (NUM_CH - 1 - c) * CH_W;
    logic [ACC_W-1:0] pa, pb;
    assign pa       = ACC_W'(a_rgb[SH +: CH_W]) * ACC_W'(w_lo);
    assign pb       = ACC_W'(b_rgb[SH +: CH_W]) * ACC_W'(rem_i);
    assign acc_d[c] = pa + pb;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[c] <= acc_d[c];
      end
    end

    assign acc_o[c] = acc_q[c];
  end

endmodule

// File: hdl/cri_flow.sv
// Valid and final-entry flags per stage, with the per-stage advance chain.
module cri_flow import cri_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_ready_i,
  input  logic  last_i,
  output flow_t flow_o
);

  logic [PIPE_DEPTH-1:0] v_d, v_q;
  logic [PIPE_DEPTH-1:0] last_d, last_q;
  logic [PIPE_DEPTH:0]   rdy;

  always_comb begin
    rdy[PIPE_DEPTH] = out_ready_i;
    for (int s = PIPE_DEPTH - 1; s >= 0; s--) begin
      rdy[s] = !v_q[s] || rdy[s+1];
    end
    v_d[0]    = rdy[0] ? in_valid_i : v_q[0];
    last_d[0] = rdy[0] ? last_i : last_q[0];
    for (int s = 1; s < PIPE_DEPTH; s++) begin
      v_d[s]    = rdy[s] ? v_q[s-1] : v_q[s];
      last_d[s] = rdy[s] ? last_q[s-1] : last_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
  end

  assign flow_o.in_ready  = rdy[0];
  assign flow_o.out_valid = v_q[PIPE_DEPTH-1];
  assign flow_o.last      = last_q[PIPE_DEPTH-1];
  assign flow_o.load      = rdy[PIPE_DEPTH-1:0];

endmodule

// File: hdl/cri_checker.sv
// Port-level checks of the colour ramp block, bound to its top level.
module cri_checker import cri_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input logic [CH_W-1:0] red_i,
  input logic [CH_W-1:0] green_i,
  input logic [CH_W-1:0] blue_i
);

  localparam int OCC_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] occ_d, occ_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + OCC_W'(1);
    end else if (!in_acc && out_acc) begin
      occ_d = occ_q - OCC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // Hold a stalled colour word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_i) &&
                                    $stable(green_i) && $stable(blue_i))
    else $error("stalled colour word changed");

  // Never hold more words than the row has stages.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(PIPE_DEPTH))
    else $error("more words in flight than stages");

  // A colour word only leaves for an index taken earlier.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != '0)
    else $error("colour word without a pending index");

  // Back-pressure on the index side only comes from a stalled output.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("index side stalled while output drains");

endmodule

bind colormap_ramp_interpolator cri_checker u_cri_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .red_i      (out_if.red),
  .green_i    (out_if.green),
  .blue_i     (out_if.blue)
);
